// ===== hdl/lgs_pkg.sv =====
// lgs_pkg: shared types, constants and helper functions for the life-like grid step
// used by the channel interfaces, the top level and its checker; no dependencies
package lgs_pkg;

    localparam int GRID_W    = 64;
    localparam int ROW_W     = 8;
    localparam int ROWS      = 8;
    localparam int PAD_W     = 16;
    localparam int SIDE_W    = 48;
    localparam int RULE_W    = 18;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = RULE_W;
    localparam int SIDE_PER_ROW = 6;
    localparam int COUNT_W   = 4;
    localparam int SEL_W     = 5;

    // default rule: birth on 3, survival on 2 and 3
    localparam logic [RULE_W-1:0] RULE_RESET = 18'h01808;

    // survival bits start above the nine birth bits
    localparam logic [SEL_W-1:0] SURVIVE_BASE = 5'd9;

    typedef enum logic [MODE_W-1:0] {
        BND_ZERO   = 2'd0,
        BND_TORUS  = 2'd1,
        BND_KLEIN  = 2'd2,
        BND_RANDOM = 2'd3
    } t_bnd_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RULE_MASK     = 1'd0,
        CFG_BOUNDARY_MODE = 1'd1
    } t_cfg_idx;

    // bit reversal of one row by nibble, pair and bit swaps
    function automatic logic [ROW_W-1:0] bit_rev8(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        b = ((a & 8'hCC) >> 2) | ((a & 8'h33) << 2);
        return ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
    endfunction

    // west and east shifted copies of one row, returned as {west, east}
    function automatic logic [2*ROW_W-1:0] shift_row(
        input logic [ROW_W-1:0] row,
        input t_bnd_mode        mode,
        input logic             wfill,
        input logic             efill
    );
        logic w_top;
        logic e_bot;
        unique case (mode)
            BND_TORUS, BND_KLEIN: begin
                w_top = row[0];
                e_bot = row[ROW_W-1];
            end
            BND_RANDOM: begin
                w_top = wfill;
                e_bot = efill;
            end
            default: begin
                w_top = 1'b0;
                e_bot = 1'b0;
            end
        endcase
        return {w_top, row[ROW_W-1:1], row[ROW_W-2:0], e_bot};
    endfunction

    // next state of one row from its three-row window
    function automatic logic [ROW_W-1:0] next_row(
        input logic [RULE_W-1:0]       rule,
        input t_bnd_mode               mode,
        input logic [ROW_W-1:0]        above,
        input logic [ROW_W-1:0]        centre,
        input logic [ROW_W-1:0]        below,
        input logic [SIDE_PER_ROW-1:0] side
    );
        logic [ROW_W-1:0]   plain [3];
        logic [ROW_W-1:0]   west  [3];
        logic [ROW_W-1:0]   east  [3];
        logic [2*ROW_W-1:0] sh;
        logic [COUNT_W-1:0] cnt;
        logic [SEL_W-1:0]   sel;
        logic [ROW_W-1:0]   res;
        plain[0] = above;
        plain[1] = centre;
        plain[2] = below;
        for (int k = 0; k < 3; k++) begin
            sh = shift_row(plain[k], mode, side[2*k], side[2*k+1]);
            west[k] = sh[2*ROW_W-1:ROW_W];
            east[k] = sh[ROW_W-1:0];
        end
        // per column: eight neighbor bits, then rule lookup
        for (int j = 0; j < ROW_W; j++) begin
            cnt = COUNT_W'(west[0][j]) + COUNT_W'(east[0][j]) + COUNT_W'(plain[0][j])
                + COUNT_W'(west[1][j]) + COUNT_W'(east[1][j])
                + COUNT_W'(west[2][j]) + COUNT_W'(east[2][j]) + COUNT_W'(plain[2][j]);
            sel = centre[j] ? (SURVIVE_BASE + SEL_W'(cnt)) : SEL_W'(cnt);
            res[j] = rule[sel];
        end
        return res;
    endfunction

endpackage

// ===== hdl/lgs_in_if.sv =====
// lgs_in_if: valid/ready channel carrying one grid word and its random border bits
// depends on lgs_pkg for field widths
interface lgs_in_if
    import lgs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [GRID_W-1:0]   current_grid;
    logic [PAD_W-1:0]    pad_random;
    logic [SIDE_W-1:0]   side_random;

    modport source (output valid, current_grid, pad_random, side_random, input ready);
    modport sink   (input valid, current_grid, pad_random, side_random, output ready);
endinterface

// ===== hdl/lgs_out_if.sv =====
// lgs_out_if: valid/ready channel carrying one next-generation grid word
// depends on lgs_pkg for field widths
interface lgs_out_if
    import lgs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [GRID_W-1:0]   next_grid;

    modport source (output valid, next_grid, input ready);
    modport sink   (input valid, next_grid, output ready);
endinterface

// ===== hdl/life_like_grid_step_top.sv =====
// the result passes through the input register and then the result register
// throughput: one grid word per cycle while the output is not stalled; the generation step is a single combinational
// pass of neighbor counts and rule lookups between the two registers
// both stages pass on ready, so while a result waits the input takes a transfer only into an empty input stage
// reset (synchronous, active low) empties both stages and restores rule 0x1808, zero border
// depends on lgs_pkg, lgs_in_if, lgs_out_if
module life_like_grid_step_top
    import lgs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lgs_in_if.sink                i_in,
    lgs_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [RULE_W-1:0] r_rule;
    t_bnd_mode         r_mode;

    logic              r_s1_valid;
    logic [GRID_W-1:0] r_s1_grid;
    logic [PAD_W-1:0]  r_s1_pad;
    logic [SIDE_W-1:0] r_s1_side;

    logic              r_out_valid;
    logic [GRID_W-1:0] r_out_grid;

    logic              s1_advance;
    logic              in_xfer;
    logic [ROW_W-1:0]  rows [ROWS+2];
    logic [GRID_W-1:0] n_out_grid;

    // handshake: each stage moves when the one after it has room
    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.next_grid = r_out_grid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= RULE_RESET;
            r_mode <= BND_ZERO;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RULE_MASK:     r_rule <= i_cfg_data[RULE_W-1:0];
                CFG_BOUNDARY_MODE: r_mode <= t_bnd_mode'(i_cfg_data[MODE_W-1:0]);
                default:           r_rule <= r_rule;
            endcase
        end
    end

    // grid rows with vertical padding above and below
    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            rows[i+1] = r_s1_grid[i*ROW_W +: ROW_W];
        end
        unique case (r_mode)
            BND_TORUS: begin
                rows[0]      = rows[ROWS];
                rows[ROWS+1] = rows[1];
            end
            BND_KLEIN: begin
                rows[0]      = bit_rev8(rows[ROWS]);
                rows[ROWS+1] = bit_rev8(rows[1]);
            end
            BND_RANDOM: begin
                rows[0]      = r_s1_pad[ROW_W-1:0];
                rows[ROWS+1] = r_s1_pad[PAD_W-1:ROW_W];
            end
            default: begin
                rows[0]      = '0;
                rows[ROWS+1] = '0;
            end
        endcase
    end

    // one generation, row by row
    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            n_out_grid[i*ROW_W +: ROW_W] = next_row(r_rule, r_mode, rows[i], rows[i+1],
                rows[i+2], r_s1_side[i*SIDE_PER_ROW +: SIDE_PER_ROW]);
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (in_xfer) begin
            r_s1_grid <= i_in.current_grid;
            r_s1_pad  <= i_in.pad_random;
            r_s1_side <= i_in.side_random;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_advance) begin
            r_out_grid <= n_out_grid;
        end
    end

endmodule

// ===== hdl/lgs_checker.sv =====
// lgs_checker: port-level checks of the grid step handshake and latency
// depends on lgs_pkg; bound to life_like_grid_step_top
module lgs_checker
    import lgs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [GRID_W-1:0] out_grid
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_grid))
        else $error("stalled result changed");

    // a ready downstream never blocks the input
    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ready |-> in_ready)
        else $error("input stalled with output ready");

    // an accepted word, followed by output ready, makes the result valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("result missing after two cycles");

endmodule

bind life_like_grid_step_top lgs_checker u_lgs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_grid  (o_out.next_grid)
);
